>>> rtl/core/sfas_pkg.sv
// Package for the single-precision add/subtract pipeline.
// Holds payload structs and shared constants; no dependencies.
package sfas_pkg;

  localparam int unsigned ExpBias = 127;
  localparam int unsigned PipeDepth = 4;

  typedef struct packed {
    logic [31:0] operand_a_bits;
    logic [31:0] operand_b_bits;
    logic        operation;
  } sfas_in_t;

  typedef struct packed {
    logic [31:0] result_bits;
    logic        range_flag;
  } sfas_out_t;

endpackage

>>> rtl/core/single_float_add_subtract.sv
// Single-precision add/subtract, truncating, four register stages.
// The start transfer reaches the done strobe through the stage valid bits v1 to v4.
// Throughput: one operand pair per cycle; busy is never raised.
// Reset clears the stage valid bits only; payload registers are not reset.
// Stages: unpack and zero check, compare and align and add, count leading bits, shift and pack.
module single_float_add_subtract
  import sfas_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  sfas_in_t  operands,
  output logic      done,
  output sfas_out_t result
);

  // Stage 1 registers: unpacked operands.
  logic               v1;
  logic signed [31:0] fa1, fb1;
  logic signed [9:0]  ea1, eb1;
  logic               sub1, bypass1;
  logic [31:0]        bypval1;

  // Stage 2 registers: sum and exponent.
  logic               v2;
  logic signed [32:0] sum2;
  logic signed [10:0] e2;
  logic               bypass2;
  logic [31:0]        bypval2;

  // Stage 3 registers: magnitude and shift count.
  logic               v3;
  logic [31:0]        mag3;
  logic [4:0]         lz3;
  logic               neg3, zero3, bypass3;
  logic signed [10:0] e3;
  logic [31:0]        bypval3;

  // Stage 4 registers: packed result.
  logic               v4;
  sfas_out_t          res4;

  logic [31:0] a_in, b_in;
  logic        a_zero, b_zero;
  logic [30:0] mag_a, mag_b;

  assign busy = 1'b0;
  assign a_in = operands.operand_a_bits;
  assign b_in = operands.operand_b_bits;
  assign a_zero = (a_in[30:0] == 31'd0);
  assign b_zero = (b_in[30:0] == 31'd0);
  assign mag_a = {1'b1, a_in[22:0], 7'd0};
  assign mag_b = {1'b1, b_in[22:0], 7'd0};

  // Stage 1: unpack, signed fractions, zero bypass.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    fa1 <= a_in[31] ? -$signed({1'b0, mag_a}) : $signed({1'b0, mag_a});
    fb1 <= b_in[31] ? -$signed({1'b0, mag_b}) : $signed({1'b0, mag_b});
    ea1 <= $signed({2'b00, a_in[30:23]}) - 10'sd127;
    eb1 <= $signed({2'b00, b_in[30:23]}) - 10'sd127;
    sub1 <= operands.operation;
    bypass1 <= a_zero | b_zero;
    bypval1 <= a_zero ? (operands.operation ? {~b_in[31], b_in[30:0]} : b_in) : a_in;
  end

  // Stage 2: align the operand with the smaller exponent and add or subtract the halved fractions.
  logic signed [10:0] diff;
  logic [4:0]         sh;
  logic signed [31:0] al_a, al_b;
  logic signed [32:0] ha, hb;

  always_comb begin
    diff = {ea1[9], ea1} - {eb1[9], eb1};
    al_a = fa1;
    al_b = fb1;
    sh = 5'd0;
    if (diff > 0) begin
      sh = (diff > 11'sd31) ? 5'd31 : diff[4:0];
      al_b = fb1 >>> sh;
    end else if (diff < 0) begin
      sh = (diff < -11'sd31) ? 5'd31 : 5'(-diff);
      al_a = fa1 >>> sh;
    end
    ha = $signed({al_a[31], al_a}) >>> 1;
    hb = $signed({al_b[31], al_b}) >>> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    sum2 <= sub1 ? ha - hb : ha + hb;
    e2 <= ((diff < 0) ? {eb1[9], eb1} : {ea1[9], ea1}) + 11'sd1;
    bypass2 <= bypass1;
    bypval2 <= bypval1;
  end

  // Stage 3: magnitude, top-bit fix and leading-zero count.
  logic [32:0] abs_s;
  logic [31:0] m;
  logic        top;
  logic [4:0]  lz;

  always_comb begin
    abs_s = sum2[32] ? 33'(-sum2) : 33'(sum2);
    top = abs_s[31];
    m = top ? abs_s[32:1] : abs_s[31:0];
    lz = 5'd0;
    for (int i = 0; i <= 30; i++) begin
      if (m[i]) begin
        lz = 5'(30 - i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    mag3 <= m;
    lz3 <= lz;
    neg3 <= sum2[32];
    zero3 <= (sum2 == 33'sd0);
    e3 <= e2 + (top ? 11'sd1 : 11'sd0);
    bypass3 <= bypass2;
    bypval3 <= bypval2;
  end

  // Stage 4: normalize, pack and range check, or pass a bypass or zero result.
  logic [31:0]        nm;
  logic signed [10:0] bexp;

  always_comb begin
    nm = mag3 << lz3;
    bexp = e3 - 11'($unsigned({6'd0, lz3})) + 11'sd127;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    if (bypass3) begin
      res4 <= '{result_bits: bypval3, range_flag: 1'b0};
    end else if (zero3) begin
      res4 <= '{result_bits: 32'd0, range_flag: 1'b0};
    end else begin
      res4 <= '{result_bits: {neg3, bexp[7:0], nm[29:7]},
                range_flag: (bexp < 11'sd1) || (bexp > 11'sd254)};
    end
  end

  assign done = v4;
  assign result = res4;

  // A stage 3 valid always reaches done through the stage 4 valid register.
  assert property (@(posedge clk) disable iff (rst) v3 |=> done)
    else $error("done lost after stage 3");
  assert property (@(posedge clk) disable iff (rst)
    done && !$past(bypass3) && !$past(zero3) |-> $past(nm[30]))
    else $error("normalized magnitude lacks leading one");
  assert property (@(posedge clk) disable iff (rst)
    done && $past(zero3) && !$past(bypass3) |-> result.result_bits == 32'd0)
    else $error("zero sum not packed as +0");

endmodule

>>> dv/sfas_checker.sv
`timescale 1ns / 1ps
// Checker for the single-precision add/subtract block: predicts each result
// from the accepted operand pair and compares it with the done strobe. Uses sfas_pkg.
module sfas_checker
  import sfas_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      busy,
  input  sfas_in_t  operands,
  input  logic      done,
  input  sfas_out_t result,
  output int        fail_count,
  output int        pending_count
);

  localparam logic [31:0] SignBit = 32'h8000_0000;
  localparam logic [31:0] FracField = 32'h3FFF_FF80;
  localparam logic [31:0] HiddenOne = 32'h4000_0000;
  localparam int unsigned OpSub = 1;

  sfas_out_t sums_waiting[$];

  // Arithmetic right shift toward minus infinity.
  function automatic longint shift_down(longint v, int n);
    shift_down = v >>> n;
  endfunction

  // Unpack to signed fraction with the hidden one at bit 30.
  function automatic longint frac_of(logic [31:0] bits);
    longint m;
    m = longint'(((bits << 7) & FracField) | HiddenOne);
    frac_of = bits[31] ? -m : m;
  endfunction

  function automatic sfas_out_t predict_sum(sfas_in_t op);
    sfas_out_t r;
    longint fa, fb, total;
    longint unsigned mag;
    int ea, eb, diff, e, biased;
    r = '0;
    if (op.operand_a_bits[30:0] == '0) begin
      r.result_bits = op.operation ? (op.operand_b_bits ^ SignBit) : op.operand_b_bits;
      return r;
    end
    if (op.operand_b_bits[30:0] == '0) begin
      r.result_bits = op.operand_a_bits;
      return r;
    end
    fa = frac_of(op.operand_a_bits);
    fb = frac_of(op.operand_b_bits);
    ea = int'(op.operand_a_bits[30:23]) - int'(ExpBias);
    eb = int'(op.operand_b_bits[30:23]) - int'(ExpBias);
    diff = ea - eb;
    // Align the operand with the smaller exponent.
    if (diff > 0) begin
      fb = shift_down(fb, diff > 31 ? 31 : diff);
      e = ea;
    end else if (diff < 0) begin
      fa = shift_down(fa, diff < -31 ? 31 : -diff);
      e = eb;
    end else begin
      e = ea;
    end
    if (op.operation == OpSub[0]) total = shift_down(fa, 1) - shift_down(fb, 1);
    else total = shift_down(fa, 1) + shift_down(fb, 1);
    e = e + 1;
    if (total == 0) return r;
    // Normalize the magnitude so its leading one sits at bit 30.
    mag = total < 0 ? longint'(-total) : longint'(total);
    if (mag[31]) begin
      mag = mag >> 1;
      e = e + 1;
    end
    while (mag[30] == 1'b0) begin
      mag = mag << 1;
      e = e - 1;
    end
    biased = e + int'(ExpBias);
    r.result_bits = {total < 0, biased[7:0], mag[29:7]};
    r.range_flag = (biased < 1 || biased > 254);
    return r;
  endfunction

  // Queue predictions on each transfer and compare each done strobe.
  always @(posedge clk) begin
    sfas_out_t want;
    if (rst) begin
      sums_waiting.delete();
      fail_count <= 0;
    end else begin
      if (done) begin
        if (sums_waiting.size() == 0) begin
          $display("%0t: result %h/%b with nothing expected", $time,
                   result.result_bits, result.range_flag);
          fail_count <= fail_count + 1;
        end else begin
          want = sums_waiting.pop_front();
          if (want.result_bits !== result.result_bits ||
              want.range_flag !== result.range_flag) begin
            $display("%0t: expected %h/%b, got %h/%b", $time, want.result_bits,
                     want.range_flag, result.result_bits, result.range_flag);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) sums_waiting.push_back(predict_sum(operands));
    end
    pending_count <= sums_waiting.size();
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Top of the add/subtract testbench: clock, reset, operand stimulus and verdict.
// Depends on sfas_pkg, the block and sfas_checker.
module tb_top;
  import sfas_pkg::*;

  localparam int RandomCount = 1950;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  sfas_in_t operands = '0;
  sfas_out_t result;
  int fail_count, pending_count;

  always #6 clk = ~clk;

  single_float_add_subtract i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operands(operands), .done(done), .result(result)
  );

  sfas_checker i_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operands(operands),
    .done(done), .result(result), .fail_count(fail_count),
    .pending_count(pending_count)
  );

  // Random operand with a biased exponent so that sums often interact.
  function automatic logic [31:0] pick_operand(logic [31:0] other);
    logic [31:0] v;
    int kind;
    v = $urandom();
    kind = $urandom_range(0, 9);
    if (kind < 4) v[30:23] = other[30:23] + 8'($urandom_range(0, 6)) - 8'd3;
    else if (kind == 4) v[22:0] = other[22:0];
    else if (kind == 5) v[30:0] = '0;
    else if (kind == 6) v[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    else if (kind == 7) v[30:23] = 8'($urandom_range(100, 154));
    return v;
  endfunction

  // Present one operand pair and hold it until the transfer happens.
  task automatic send(logic [31:0] a, logic [31:0] b, logic sub, bit allow_gaps);
    int gap;
    if (allow_gaps && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      gap = $urandom_range(1, 16);
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    operands <= '{operand_a_bits: a, operand_b_bits: b, operation: sub};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    logic [31:0] a, b;
    int wait_left;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: zeros, sign flips, exact cancel, extremes, wide shift, wrap.
    send(32'h0000_0000, 32'h3F80_0000, 1'b0, 0);
    send(32'h8000_0000, 32'h3F80_0000, 1'b1, 0);
    send(32'h4040_0000, 32'h8000_0000, 1'b1, 0);
    send(32'h0000_0000, 32'h8000_0000, 1'b0, 0);
    send(32'h3F80_0000, 32'h3F80_0000, 1'b1, 0);
    send(32'h3F80_0000, 32'hBF80_0000, 1'b0, 0);
    send(32'h3F80_0000, 32'h3F80_0000, 1'b0, 0);
    send(32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b0, 0);
    send(32'h0080_0000, 32'h8000_0001, 1'b0, 0);
    send(32'h0080_0000, 32'h0080_0001, 1'b1, 0);
    send(32'h7F80_0000, 32'h0000_0001, 1'b0, 0);
    send(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 0);
    send(32'h3F80_0000, 32'h5000_0000, 1'b0, 0);
    send(32'hC000_0000, 32'h3F80_0000, 1'b0, 0);
    send(32'hBF80_0000, 32'h3F00_0000, 1'b1, 0);
    send(32'h4000_0000, 32'h3FFF_FFFF, 1'b1, 0);
    send(32'h0000_0001, 32'hFF80_0000, 1'b1, 0);
    send(32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 0);
    // Random part; the last stretch runs without gaps.
    for (int i = 0; i < RandomCount; i++) begin
      a = $urandom();
      if ($urandom_range(0, 7) == 0) a[30:0] = '0;
      b = pick_operand(a);
      send(a, b, 1'($urandom_range(0, 1)), i < RandomCount - 200);
    end
    start <= 1'b0;
    wait_left = 1000;
    while ((pending_count != 0 || i_checker.sums_waiting.size() != 0) && wait_left > 0) begin
      @(posedge clk);
      wait_left--;
    end
    repeat (PipeDepth + 4) @(posedge clk);
    if (fail_count == 0 && wait_left > 0) $display("** single_float_add_subtract: PASSED **");
    else $display("** single_float_add_subtract: FAILED **");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** single_float_add_subtract: FAILED **");
    $finish;
  end

endmodule

>>> single_float_add_subtract.f
rtl/core/sfas_pkg.sv
rtl/core/single_float_add_subtract.sv
dv/sfas_checker.sv
dv/tb_top.sv
